[hw/rtl/atbt_pkg.sv]
// Shared types, constants and the arctangent table of the batch tilt angle core.
`default_nettype none

package atbt_pkg;

	// Default configuration of the core.
	localparam int MAX_BATCH_DEF    = 32;
	localparam int ANGLE_FRAC_DEF   = 7;
	localparam int CORDIC_ITERS_DEF = 16;

	// Fixed field widths of the channels and the configuration port.
	localparam int ACCEL_W     = 16;
	localparam int REF_W       = 15;
	localparam int DELTA_W     = 16;
	localparam int COUNT_OUT_W = 6;
	localparam int CFG_IDX_W   = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REF_ROLL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_PITCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_YAW   = 2'd2;

	// CORDIC number formats: angles in degrees with TAB_FRAC fraction bits.
	localparam int TAB_FRAC  = 20;
	localparam int TAB_LEN   = 24;
	localparam int TAB_IDX_W = 5;
	localparam int ACC_W     = 30;
	localparam int CORDIC_W  = 44;
	localparam int NORM_LOG  = 40;
	localparam int FAST_STEP = 8;
	localparam int DEG_180   = 180;

	// Sequencer states of the core.
	typedef enum logic [2:0] {
		S_ACCUM,
		S_SQUARE,
		S_ROOT_GO,
		S_ROOT_WAIT,
		S_ANGLE_GO,
		S_ANGLE_WAIT,
		S_EMIT
	} core_state_t;

	// States of the CORDIC unit.
	typedef enum logic [1:0] {
		C_IDLE,
		C_NORM,
		C_ROTATE,
		C_FINISH
	} cordic_state_t;

	// The three tilt angles, worked one after the other.
	typedef enum logic [1:0] {
		AX_ROLL,
		AX_PITCH,
		AX_YAW
	} axis_t;

	// atan(2^-i) in degrees with TAB_FRAC fraction bits, rounded to nearest.
	function automatic logic [ACC_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
		unique case (idx)
			5'd0:    atan_entry = ACC_W'(47185920);
			5'd1:    atan_entry = ACC_W'(27855475);
			5'd2:    atan_entry = ACC_W'(14718068);
			5'd3:    atan_entry = ACC_W'(7471121);
			5'd4:    atan_entry = ACC_W'(3750058);
			5'd5:    atan_entry = ACC_W'(1876857);
			5'd6:    atan_entry = ACC_W'(938658);
			5'd7:    atan_entry = ACC_W'(469357);
			5'd8:    atan_entry = ACC_W'(234682);
			5'd9:    atan_entry = ACC_W'(117342);
			5'd10:   atan_entry = ACC_W'(58671);
			5'd11:   atan_entry = ACC_W'(29335);
			5'd12:   atan_entry = ACC_W'(14668);
			5'd13:   atan_entry = ACC_W'(7334);
			5'd14:   atan_entry = ACC_W'(3667);
			5'd15:   atan_entry = ACC_W'(1833);
			5'd16:   atan_entry = ACC_W'(917);
			5'd17:   atan_entry = ACC_W'(458);
			5'd18:   atan_entry = ACC_W'(229);
			5'd19:   atan_entry = ACC_W'(115);
			5'd20:   atan_entry = ACC_W'(57);
			5'd21:   atan_entry = ACC_W'(29);
			5'd22:   atan_entry = ACC_W'(14);
			5'd23:   atan_entry = ACC_W'(7);
			default: atan_entry = '0;
		endcase
	endfunction

endpackage

`default_nettype wire

[hw/rtl/atbt_sample_if.sv]
// Valid/ready channel that carries one accelerometer sample per transfer.
`default_nettype none

interface atbt_sample_if import atbt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ACCEL_W-1:0] accel_x;
	logic signed [ACCEL_W-1:0] accel_y;
	logic signed [ACCEL_W-1:0] accel_z;
	logic                      batch_end;

	modport source (output valid, accel_x, accel_y, accel_z, batch_end, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, batch_end, output ready);
endinterface

`default_nettype wire

[hw/rtl/atbt_result_if.sv]
// Valid/ready channel that carries one set of tilt angle deltas per transfer.
`default_nettype none

interface atbt_result_if import atbt_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DELTA_W-1:0] delta_roll;
	logic signed [DELTA_W-1:0] delta_pitch;
	logic signed [DELTA_W-1:0] delta_yaw;
	logic [COUNT_OUT_W-1:0]    samples_used;
	logic                      batch_overflow;

	modport source (output valid, delta_roll, delta_pitch, delta_yaw, samples_used,
		batch_overflow, input ready);
	modport sink (input valid, delta_roll, delta_pitch, delta_yaw, samples_used,
		batch_overflow, output ready);
endinterface

`default_nettype wire

[hw/rtl/atbt_isqrt.sv]
// Iterative floor square root, one root bit per clock cycle.
`default_nettype none

module atbt_isqrt import atbt_pkg::*; #(
	parameter int ROOT_W = 22
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [2*ROOT_W-1:0]   radicand,
	output logic                       done,
	output logic [ROOT_W-1:0]          root
);

	localparam int RAD_W = 2 * ROOT_W;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              fits;

	// Bring down the next two radicand bits and try a one for the next root bit.
	always_comb begin
		rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	// Step counter and handshake flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and partial root.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

	// A new root is only started once the previous one has finished.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("square root started while busy");

endmodule

`default_nettype wire

[hw/rtl/atbt_cordic.sv]
// Iterative CORDIC vectoring unit that returns atan2(y, x) in fixed-point degrees.
`default_nettype none

module atbt_cordic import atbt_pkg::*; #(
	parameter int IN_W            = 23,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
	parameter int CORDIC_ITERS    = CORDIC_ITERS_DEF,
	parameter int ANG_W           = ANGLE_FRAC_BITS + 9
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [IN_W-1:0]  y_in,
	input  wire logic signed [IN_W-1:0]  x_in,
	output logic                         done,
	output logic signed [ANG_W-1:0]      angle
);

	localparam int IT_W = $clog2(CORDIC_ITERS);
	localparam int SH   = TAB_FRAC - ANGLE_FRAC_BITS;

	localparam logic signed [CORDIC_W-1:0] ONE_W    = CORDIC_W'(1);
	localparam logic signed [CORDIC_W-1:0] NORM_POS = ONE_W << NORM_LOG;
	localparam logic signed [CORDIC_W-1:0] NORM_NEG = -NORM_POS;
	localparam logic signed [CORDIC_W-1:0] FAST_POS = ONE_W << (NORM_LOG - FAST_STEP + 1);
	localparam logic signed [CORDIC_W-1:0] FAST_NEG = -FAST_POS;
	localparam logic signed [ACC_W-1:0]    ONE_A    = ACC_W'(1);
	localparam logic signed [ACC_W-1:0]    DEG180   = ACC_W'(DEG_180) << TAB_FRAC;
	localparam logic signed [ACC_W-1:0]    HALF     = ONE_A << (SH - 1);

	cordic_state_t state_q, state_d;

	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic [IT_W-1:0]            it_q;
	logic                       xneg_q, yneg_q;
	logic                       done_q;
	logic signed [ANG_W-1:0]    angle_q;

	logic signed [CORDIC_W-1:0] x_sh, y_sh, x_ext;
	logic signed [ACC_W-1:0]    tab;
	logic signed [ACC_W-1:0]    folded;
	logic signed [ACC_W-1:0]    rounded;
	logic                       in_norm, in_fast, last_it;

	// Shifted operands, range checks and the final angle.
	always_comb begin
		x_ext   = CORDIC_W'(x_in);
		x_sh    = x_q >>> it_q;
		y_sh    = y_q >>> it_q;
		tab     = signed'(atan_entry(TAB_IDX_W'(it_q)));
		in_norm = (x_q < NORM_POS) && (x_q > NORM_NEG) && (y_q < NORM_POS) && (y_q > NORM_NEG);
		in_fast = (x_q < FAST_POS) && (x_q > FAST_NEG) && (y_q < FAST_POS) && (y_q > FAST_NEG);
		last_it = it_q == IT_W'(CORDIC_ITERS - 1);
		// A vector in the left half plane was mirrored; fold its angle back.
		priority if (!xneg_q) begin
			folded = acc_q;
		end else if (!yneg_q) begin
			folded = DEG180 - acc_q;
		end else begin
			folded = -DEG180 - acc_q;
		end
		rounded = (folded + HALF) >>> SH;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == C_FINISH;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					// A zero vector has angle zero and skips the rotation.
					if (y_in == '0 && x_in == '0) begin
						state_d = C_FINISH;
					end else begin
						state_d = C_NORM;
					end
				end
			end
			C_NORM: begin
				if (!in_norm) begin
					state_d = C_ROTATE;
				end
			end
			C_ROTATE: begin
				if (last_it) begin
					state_d = C_FINISH;
				end
			end
			C_FINISH: state_d = C_IDLE;
			default:  state_d = C_IDLE;
		endcase
	end

	// Shared add/shift datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					x_q    <= x_in[IN_W-1] ? -x_ext : x_ext;
					y_q    <= CORDIC_W'(y_in);
					xneg_q <= x_in[IN_W-1];
					yneg_q <= y_in[IN_W-1];
					acc_q  <= '0;
					it_q   <= '0;
				end
			end
			C_NORM: begin
				// Scale both operands up together until one reaches the limit.
				if (in_fast) begin
					x_q <= x_q <<< FAST_STEP;
					y_q <= y_q <<< FAST_STEP;
				end else if (in_norm) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			C_ROTATE: begin
				if (!y_q[CORDIC_W-1]) begin
					x_q   <= x_q + y_sh;
					y_q   <= y_q - x_sh;
					acc_q <= acc_q + tab;
				end else begin
					x_q   <= x_q - y_sh;
					y_q   <= y_q + x_sh;
					acc_q <= acc_q - tab;
				end
				it_q <= it_q + IT_W'(1);
			end
			C_FINISH: angle_q <= ANG_W'(rounded);
			default: begin
			end
		endcase
	end

	assign done  = done_q;
	assign angle = angle_q;

	// Starts come only while the unit is free.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == C_IDLE)
		else $error("CORDIC started while busy");

	// The x component never goes negative once the vector is in the right half plane.
	a_x_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_ROTATE |-> !x_q[CORDIC_W-1])
		else $error("CORDIC x component went negative");

endmodule

`default_nettype wire

[hw/rtl/accel_batch_tilt_angles_core.sv]
// Top level of the batch tilt angle core: sample sums, sequencer and result register.
`default_nettype none

// Accumulates three-axis accelerometer samples, up to MAX_BATCH per batch, and on the
// sample marked batch_end returns roll, pitch and yaw tilt angles minus the reference
// angles held in the configuration registers, in degrees with ANGLE_FRAC_BITS fraction
// bits and saturated to 16 bits. Samples that arrive once the batch is full are dropped
// and reported through batch_overflow. A sample without batch_end is taken without a stall.
// A batch end keeps the input stalled while the angles are worked out: the three sums are
// squared one after the other on the single multiplier, then three square roots run on the
// shared root unit, then three passes of the shared CORDIC unit each normalize and rotate
// (a pass skips both when both operands are zero), then the result register is loaded,
// which waits while the previous result is still held. The result register lets the next
// batch start while the previous result waits to be taken.
module accel_batch_tilt_angles_core import atbt_pkg::*; #(
	parameter int MAX_BATCH       = MAX_BATCH_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF,
	parameter int CORDIC_ITERS    = CORDIC_ITERS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	atbt_sample_if.sink               in_ch,
	atbt_result_if.source             out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REF_W-1:0]     cfg_wdata
);

	localparam int CNT_W  = $clog2(MAX_BATCH + 1);
	localparam int SUM_W  = ACCEL_W + CNT_W;
	localparam int SQ_W   = 2 * SUM_W - 1;
	localparam int RAD_W  = 2 * SUM_W;
	localparam int IN_W   = SUM_W + 1;
	localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
	localparam int DIFF_W = (ANG_W > DELTA_W ? ANG_W : DELTA_W) + 1;

	localparam logic signed [DIFF_W-1:0] D_MAX = DIFF_W'((1 << (DELTA_W - 1)) - 1);
	localparam logic signed [DIFF_W-1:0] D_MIN = DIFF_W'(-(1 << (DELTA_W - 1)));

	core_state_t state_q, state_d;
	axis_t       axis_q, axis_nx;

	// Batch state.
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;

	// Reference angles.
	logic signed [REF_W-1:0] ref_roll_q, ref_pitch_q;
	logic [REF_W-1:0]        ref_yaw_q;

	// Intermediate results.
	logic [SQ_W-1:0]           sq_x_q, sq_y_q, sq_z_q;
	logic [SUM_W-1:0]          root_roll_q, root_pitch_q, root_yaw_q;
	logic signed [DELTA_W-1:0] delta_roll_q, delta_pitch_q, delta_yaw_q;

	// Result register.
	logic                      out_valid_q;
	logic signed [DELTA_W-1:0] res_roll_q, res_pitch_q, res_yaw_q;
	logic [COUNT_OUT_W-1:0]    res_count_q;
	logic                      res_ovf_q;

	logic                      in_xfer, out_xfer, emit_load;
	logic                      sqrt_start, sqrt_done;
	logic                      cordic_start, cordic_done;
	logic signed [SUM_W-1:0]   sq_op;
	logic signed [RAD_W-1:0]   product;
	logic [RAD_W-1:0]          radicand;
	logic [SUM_W-1:0]          root;
	logic signed [IN_W-1:0]    cordic_y, cordic_x;
	logic signed [ANG_W-1:0]   cordic_angle;
	logic signed [DIFF_W-1:0]  ref_ext, diff;
	logic signed [DELTA_W-1:0] delta_sat;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_valid_q && out_ch.ready;

	// Per-axis operand selection for the multiplier, root and CORDIC units.
	always_comb begin
		unique case (axis_q)
			AX_ROLL: begin
				axis_nx  = AX_PITCH;
				sq_op    = sum_x_q;
				radicand = RAD_W'(sq_y_q) + RAD_W'(sq_z_q);
				cordic_y = IN_W'(sum_x_q);
				cordic_x = signed'({1'b0, root_roll_q});
				ref_ext  = DIFF_W'(ref_roll_q);
			end
			AX_PITCH: begin
				axis_nx  = AX_YAW;
				sq_op    = sum_y_q;
				radicand = RAD_W'(sq_x_q) + RAD_W'(sq_z_q);
				cordic_y = IN_W'(sum_y_q);
				cordic_x = signed'({1'b0, root_pitch_q});
				ref_ext  = DIFF_W'(ref_pitch_q);
			end
			default: begin
				axis_nx  = AX_ROLL;
				sq_op    = sum_z_q;
				radicand = RAD_W'(sq_x_q) + RAD_W'(sq_y_q);
				cordic_y = signed'({1'b0, root_yaw_q});
				cordic_x = IN_W'(sum_z_q);
				ref_ext  = signed'(DIFF_W'(ref_yaw_q));
			end
		endcase
	end

	// Single squaring multiplier.
	assign product = sq_op * sq_op;

	// Angle minus reference, saturated to the result width.
	always_comb begin
		diff = DIFF_W'(cordic_angle) - ref_ext;
		priority if (diff > D_MAX) begin
			delta_sat = DELTA_W'(D_MAX);
		end else if (diff < D_MIN) begin
			delta_sat = DELTA_W'(D_MIN);
		end else begin
			delta_sat = DELTA_W'(diff);
		end
	end

	atbt_isqrt #(
		.ROOT_W(SUM_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.done     (sqrt_done),
		.root     (root)
	);

	atbt_cordic #(
		.IN_W            (IN_W),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_ITERS    (CORDIC_ITERS),
		.ANG_W           (ANG_W)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.y_in   (cordic_y),
		.x_in   (cordic_x),
		.done   (cordic_done),
		.angle  (cordic_angle)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACCUM;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and unit strobes.
	always_comb begin
		state_d      = state_q;
		in_ch.ready  = 1'b0;
		sqrt_start   = 1'b0;
		cordic_start = 1'b0;
		emit_load    = 1'b0;
		unique case (state_q)
			S_ACCUM: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid && in_ch.batch_end) begin
					state_d = S_SQUARE;
				end
			end
			S_SQUARE: begin
				if (axis_q == AX_YAW) begin
					state_d = S_ROOT_GO;
				end
			end
			S_ROOT_GO: begin
				sqrt_start = 1'b1;
				state_d    = S_ROOT_WAIT;
			end
			S_ROOT_WAIT: begin
				if (sqrt_done) begin
					state_d = (axis_q == AX_YAW) ? S_ANGLE_GO : S_ROOT_GO;
				end
			end
			S_ANGLE_GO: begin
				cordic_start = 1'b1;
				state_d      = S_ANGLE_WAIT;
			end
			S_ANGLE_WAIT: begin
				if (cordic_done) begin
					state_d = (axis_q == AX_YAW) ? S_EMIT : S_ANGLE_GO;
				end
			end
			S_EMIT: begin
				// Wait for the result register to be free or emptied this cycle.
				if (!out_valid_q || out_ch.ready) begin
					emit_load = 1'b1;
					state_d   = S_ACCUM;
				end
			end
			default: state_d = S_ACCUM;
		endcase
	end

	// Control state: axis pointer, batch state, references and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q      <= AX_ROLL;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			ref_roll_q  <= '0;
			ref_pitch_q <= '0;
			ref_yaw_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Sample transfer: add it in unless the batch is full.
			if (in_xfer) begin
				if (count_q < CNT_W'(MAX_BATCH)) begin
					sum_x_q <= sum_x_q + SUM_W'(in_ch.accel_x);
					sum_y_q <= sum_y_q + SUM_W'(in_ch.accel_y);
					sum_z_q <= sum_z_q + SUM_W'(in_ch.accel_z);
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end

			// Step to the next axis as each unit pass completes.
			if ((state_q == S_SQUARE) || (state_q == S_ROOT_WAIT && sqrt_done) ||
					(state_q == S_ANGLE_WAIT && cordic_done)) begin
				axis_q <= axis_nx;
			end

			// The batch is cleared when its result is loaded.
			if (emit_load) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end

			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end

			// Configuration writes; indexes past the list are ignored.
			if (cfg_we) begin
				unique case (cfg_index)
					REG_REF_ROLL:  ref_roll_q  <= signed'(cfg_wdata);
					REG_REF_PITCH: ref_pitch_q <= signed'(cfg_wdata);
					REG_REF_YAW:   ref_yaw_q   <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

	// Intermediate and result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_SQUARE) begin
			unique case (axis_q)
				AX_ROLL:  sq_x_q <= SQ_W'(product);
				AX_PITCH: sq_y_q <= SQ_W'(product);
				default:  sq_z_q <= SQ_W'(product);
			endcase
		end
		if (state_q == S_ROOT_WAIT && sqrt_done) begin
			unique case (axis_q)
				AX_ROLL:  root_roll_q  <= root;
				AX_PITCH: root_pitch_q <= root;
				default:  root_yaw_q   <= root;
			endcase
		end
		if (state_q == S_ANGLE_WAIT && cordic_done) begin
			unique case (axis_q)
				AX_ROLL:  delta_roll_q  <= delta_sat;
				AX_PITCH: delta_pitch_q <= delta_sat;
				default:  delta_yaw_q   <= delta_sat;
			endcase
		end
		if (emit_load) begin
			res_roll_q  <= delta_roll_q;
			res_pitch_q <= delta_pitch_q;
			res_yaw_q   <= delta_yaw_q;
			res_count_q <= COUNT_OUT_W'(count_q);
			res_ovf_q   <= ovf_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.delta_roll     = res_roll_q;
	assign out_ch.delta_pitch    = res_pitch_q;
	assign out_ch.delta_yaw      = res_yaw_q;
	assign out_ch.samples_used   = res_count_q;
	assign out_ch.batch_overflow = res_ovf_q;

	// The sample count never passes the batch limit.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BATCH))
		else $error("sample count beyond batch limit");

	// Samples are only dropped once the batch is full.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == CNT_W'(MAX_BATCH))
		else $error("overflow flagged on a batch that is not full");

	// A new result appears only out of the emit step.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result valid raised outside the emit step");

endmodule

`default_nettype wire

[tb/sv/accel_batch_tilt_angles_core_test.sv]
// Self-checking testbench of the batch tilt angle core, with its own angle predictor.
`timescale 1ns / 1ps

module accel_batch_tilt_angles_core_test;
	import atbt_pkg::*;

	localparam int  QUIET_LIMIT   = 5000;
	localparam int  SETTLE_CYCLES = 200;
	localparam int  LONG_HOLD     = 800;
	localparam int  PRINT_CAP     = 40;
	localparam int  ROUND_SHIFT   = TAB_FRAC - ANGLE_FRAC_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint NORM_EDGE  = longint'(1) << NORM_LOG;
	localparam longint HALF_TURN  = longint'(DEG_180) << TAB_FRAC;

	typedef struct packed {
		logic [ACCEL_W-1:0] ax;
		logic [ACCEL_W-1:0] ay;
		logic [ACCEL_W-1:0] az;
		logic               last;
	} sample_t;

	typedef struct packed {
		logic [DELTA_W-1:0]     roll;
		logic [DELTA_W-1:0]     pitch;
		logic [DELTA_W-1:0]     yaw;
		logic [COUNT_OUT_W-1:0] used;
		logic                   spill;
	} angle_set_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REF_W-1:0]     cfg_wdata;

	atbt_sample_if in_ch();
	atbt_result_if out_ch();

	accel_batch_tilt_angles_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// atan(2^-i) in degrees with 20 fraction bits.
	longint atan_deg [0:23] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	// Predictor state: batch sums and the reference angles.
	longint                   sum_ax, sum_ay, sum_az;
	int                       batch_fill;
	bit                       batch_spilled;
	logic signed [REF_W-1:0]  tilt_ref_roll, tilt_ref_pitch;
	logic [REF_W-1:0]         tilt_ref_yaw;

	sample_t    sample_q[$];
	angle_set_t pending_angles_q[$];
	int         pending_items;

	// Idling controls, set per phase.
	bit src_gaps_on, sink_gaps_on;
	int sink_hold_cycles;
	int send_gap, take_gap;

	// Run statistics.
	int fault_count, samples_taken, batches_seen, spilled_batches, results_checked;
	int ref_settings, quiet_cycles;

	sample_t    drv_item, mon_in;
	angle_set_t mon_res, want;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	task automatic report_fault(input string msg);
		if (fault_count < PRINT_CAP)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		fault_count++;
	endtask

	// Floor square root of a 64-bit value.
	function automatic longint int_root(input longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(r);
	endfunction

	// Vectoring CORDIC for a non-negative x, angle in degrees with 20 fraction bits.
	function automatic longint cordic_vector(input longint y, input longint x);
		longint acc, xs, ys;
		int     n;
		acc = 0;
		n = (CORDIC_ITERS_DEF < TAB_LEN) ? CORDIC_ITERS_DEF : TAB_LEN;
		while (x < NORM_EDGE && x > -NORM_EDGE && y < NORM_EDGE && y > -NORM_EDGE) begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < n; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys;
				y -= xs;
				acc += atan_deg[i];
			end else begin
				x -= ys;
				y += xs;
				acc -= atan_deg[i];
			end
		end
		return acc;
	endfunction

	// Four-quadrant arctangent, rounded to the output angle format.
	function automatic longint tilt_atan2(input longint y, input longint x);
		longint a;
		if (x == 0 && y == 0)
			return 0;
		if (x >= 0)
			a = cordic_vector(y, x);
		else if (y >= 0)
			a = HALF_TURN - cordic_vector(y, -x);
		else
			a = -HALF_TURN - cordic_vector(y, -x);
		return (a + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
	endfunction

	function automatic logic [DELTA_W-1:0] clamp_delta(input longint angle, input longint refv);
		longint d;
		d = angle - refv;
		if (d > 32767)
			d = 32767;
		if (d < -32768)
			d = -32768;
		return DELTA_W'(d);
	endfunction

	// Adds one sample to the batch; on a batch end fills in the angle set and clears the batch.
	function automatic bit predict_tilt(input sample_t s, output angle_set_t r);
		longint sq_x, sq_y, sq_z;
		r = '0;
		if (batch_fill < MAX_BATCH_DEF) begin
			sum_ax += longint'(signed'(s.ax));
			sum_ay += longint'(signed'(s.ay));
			sum_az += longint'(signed'(s.az));
			batch_fill++;
		end else begin
			batch_spilled = 1'b1;
		end
		if (!s.last)
			return 1'b0;
		sq_x = sum_ax * sum_ax;
		sq_y = sum_ay * sum_ay;
		sq_z = sum_az * sum_az;
		r.roll  = clamp_delta(tilt_atan2(sum_ax, int_root(sq_y + sq_z)),
			longint'(tilt_ref_roll));
		r.pitch = clamp_delta(tilt_atan2(sum_ay, int_root(sq_x + sq_z)),
			longint'(tilt_ref_pitch));
		r.yaw   = clamp_delta(tilt_atan2(int_root(sq_x + sq_y), sum_az),
			longint'(tilt_ref_yaw));
		r.used  = COUNT_OUT_W'(batch_fill);
		r.spill = batch_spilled;
		batches_seen++;
		if (batch_spilled)
			spilled_batches++;
		sum_ax = 0;
		sum_ay = 0;
		sum_az = 0;
		batch_fill = 0;
		batch_spilled = 1'b0;
		return 1'b1;
	endfunction

	// Gap length: mostly short, now and then long.
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [ACCEL_W-1:0] pick_base();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return ACCEL_W'($urandom);
			4:          return 16'h7FFF;
			5:          return 16'h8000;
			6:          return '0;
			7:          return ACCEL_W'($urandom_range(0, 30) - 15);
			default:    return ($urandom_range(0, 1) != 0) ? ACCEL_W'(16384) : ACCEL_W'(-16384);
		endcase
	endfunction

	// A sample near the batch's base vector, or a fully random one.
	function automatic logic [ACCEL_W-1:0] jitter(input logic [ACCEL_W-1:0] base, input int mode);
		if (mode == 2)
			return ACCEL_W'($urandom);
		if (mode == 1)
			return base + ACCEL_W'($urandom_range(0, 64) - 32);
		return base;
	endfunction

	task automatic push_sample(input logic [ACCEL_W-1:0] x, input logic [ACCEL_W-1:0] y,
		input logic [ACCEL_W-1:0] z, input logic last);
		sample_t s;
		s.ax = x;
		s.ay = y;
		s.az = z;
		s.last = last;
		sample_q.push_back(s);
		pending_items++;
	endtask

	// One batch of random length and orientation, closed by a batch end.
	task automatic push_batch(output int len);
		logic [ACCEL_W-1:0] bx, by, bz;
		int                 r, mode;
		r = $urandom_range(0, 99);
		if (r < 55)
			len = $urandom_range(1, 4);
		else if (r < 80)
			len = $urandom_range(5, 12);
		else if (r < 90)
			len = $urandom_range(13, 31);
		else if (r < 95)
			len = MAX_BATCH_DEF;
		else
			len = $urandom_range(MAX_BATCH_DEF + 1, MAX_BATCH_DEF + 8);
		bx = pick_base();
		by = pick_base();
		bz = pick_base();
		mode = $urandom_range(0, 2);
		for (int k = 0; k < len; k++)
			push_sample(jitter(bx, mode), jitter(by, mode), jitter(bz, mode), k == len - 1);
	endtask

	task automatic push_random(input int n);
		int total, len;
		total = 0;
		while (total < n) begin
			push_batch(len);
			total += len;
		end
	endtask

	// Waits until every sample is taken and every result has come back.
	task automatic settle();
		while (pending_items != 0 || pending_angles_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REF_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_REF_ROLL:  tilt_ref_roll = val;
			REG_REF_PITCH: tilt_ref_pitch = val;
			REG_REF_YAW:   tilt_ref_yaw = val;
			default:       ;
		endcase
	endtask

	task automatic set_refs(input logic [REF_W-1:0] roll, input logic [REF_W-1:0] pitch,
		input logic [REF_W-1:0] yaw);
		write_reg(REG_REF_ROLL, roll);
		write_reg(REG_REF_PITCH, pitch);
		write_reg(REG_REF_YAW, yaw);
		ref_settings++;
	endtask

	// Sample source: holds each item until its transfer, then takes the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.accel_x <= '0;
			in_ch.accel_y <= '0;
			in_ch.accel_z <= '0;
			in_ch.batch_end <= 1'b0;
			send_gap = 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_ch.valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				drv_item = sample_q.pop_front();
				in_ch.accel_x <= drv_item.ax;
				in_ch.accel_y <= drv_item.ay;
				in_ch.accel_z <= drv_item.az;
				in_ch.batch_end <= drv_item.last;
				in_ch.valid <= 1'b1;
				send_gap = (src_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Result sink: random stalls, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			take_gap = 0;
		end else if (sink_hold_cycles > 0) begin
			sink_hold_cycles--;
			out_ch.ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap--;
			out_ch.ready <= 1'b0;
		end else if (sink_gaps_on && $urandom_range(0, 7) == 0) begin
			take_gap = pick_gap() - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Monitor: predicts on each sample transfer, checks each result transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				mon_in.ax = in_ch.accel_x;
				mon_in.ay = in_ch.accel_y;
				mon_in.az = in_ch.accel_z;
				mon_in.last = in_ch.batch_end;
				pending_items--;
				samples_taken++;
				if (predict_tilt(mon_in, mon_res))
					pending_angles_q.push_back(mon_res);
			end
			if (out_ch.valid && out_ch.ready) begin
				results_checked++;
				if (pending_angles_q.size() == 0) begin
					report_fault($sformatf("result with no batch pending, roll %0d pitch %0d yaw %0d",
						out_ch.delta_roll, out_ch.delta_pitch, out_ch.delta_yaw));
				end else begin
					want = pending_angles_q.pop_front();
					if (out_ch.delta_roll !== want.roll)
						report_fault($sformatf("delta_roll got %0d want %0d",
							out_ch.delta_roll, $signed(want.roll)));
					if (out_ch.delta_pitch !== want.pitch)
						report_fault($sformatf("delta_pitch got %0d want %0d",
							out_ch.delta_pitch, $signed(want.pitch)));
					if (out_ch.delta_yaw !== want.yaw)
						report_fault($sformatf("delta_yaw got %0d want %0d",
							out_ch.delta_yaw, $signed(want.yaw)));
					if (out_ch.samples_used !== want.used)
						report_fault($sformatf("samples_used got %0d want %0d",
							out_ch.samples_used, want.used));
					if (out_ch.batch_overflow !== want.spill)
						report_fault($sformatf("batch_overflow got %0b want %0b",
							out_ch.batch_overflow, want.spill));
				end
			end
			// Watchdog on cycles without any transfer.
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("accel_batch_tilt_angles_core verification failed");
				$finish;
			end
		end
	end

	// Stimulus sequence: reset, directed samples, then random phases under varied settings.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.accel_x = '0;
		in_ch.accel_y = '0;
		in_ch.accel_z = '0;
		in_ch.batch_end = 1'b0;
		out_ch.ready = 1'b0;
		sum_ax = 0;
		sum_ay = 0;
		sum_az = 0;
		batch_fill = 0;
		batch_spilled = 1'b0;
		tilt_ref_roll = '0;
		tilt_ref_pitch = '0;
		tilt_ref_yaw = '0;
		pending_items = 0;
		sink_hold_cycles = 0;
		src_gaps_on = 1'b0;
		sink_gaps_on = 1'b0;
		fault_count = 0;
		samples_taken = 0;
		batches_seen = 0;
		spilled_batches = 0;
		results_checked = 0;
		ref_settings = 1;
		quiet_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under reset references, no idling.
		// All-zero batch: both arctangent operands are zero.
		push_sample(16'h0000, 16'h0000, 16'h0000, 1'b1);
		// Each axis alone at its extremes.
		push_sample(16'h7FFF, 16'h0000, 16'h0000, 1'b1);
		push_sample(16'h8000, 16'h0000, 16'h0000, 1'b1);
		push_sample(16'h0000, 16'h7FFF, 16'h0000, 1'b1);
		push_sample(16'h0000, 16'h8000, 16'h0000, 1'b1);
		push_sample(16'h0000, 16'h0000, 16'h7FFF, 1'b1);
		// Negative z makes the second yaw operand negative.
		push_sample(16'h0000, 16'h0000, 16'h8000, 1'b1);
		push_sample(16'h8000, 16'h8000, 16'h8000, 1'b1);
		push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
		// Samples that cancel to a zero sum.
		push_sample(16'h0001, 16'h0000, 16'h0000, 1'b0);
		push_sample(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
		// Tiny values need the most normalization.
		push_sample(16'h0000, 16'h0000, 16'hFFFF, 1'b1);
		push_sample(16'h0001, 16'hFFFF, 16'h0001, 1'b1);
		push_sample(16'h4000, ACCEL_W'(-300), 16'h0005, 1'b0);
		push_sample(ACCEL_W'(16380), ACCEL_W'(-310), 16'h0002, 1'b1);
		push_sample(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
		push_sample(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
		push_sample(16'h8000, 16'h7FFF, 16'h8000, 1'b1);
		settle();

		// Largest references of the normal range, both kinds of idling.
		set_refs(REF_W'(11520), REF_W'(-11520), REF_W'(23040));
		write_reg(REG_UNUSED, REF_W'(12345));
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
		push_random(260);
		settle();

		// Extremes of the register width.
		set_refs(REF_W'(-16384), REF_W'(16383), REF_W'(32767));
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b0;
		push_random(260);
		settle();

		// Random references inside the normal range.
		set_refs(REF_W'($urandom_range(0, 23040) - 11520),
			REF_W'($urandom_range(0, 23040) - 11520), REF_W'($urandom_range(0, 23040)));
		src_gaps_on = 1'b0;
		sink_gaps_on = 1'b1;
		push_random(260);
		settle();

		// Zero references; the sink holds off while samples keep coming, so the core backs up.
		set_refs(REF_W'(0), REF_W'(0), REF_W'(0));
		src_gaps_on = 1'b0;
		sink_gaps_on = 1'b0;
		sink_hold_cycles = LONG_HOLD;
		push_random(260);
		settle();

		// Random references over the whole register width.
		set_refs(REF_W'($urandom), REF_W'($urandom), REF_W'($urandom));
		src_gaps_on = 1'b1;
		sink_gaps_on = 1'b1;
		push_random(260);
		settle();

		while (pending_angles_q.size() != 0) begin
			want = pending_angles_q.pop_front();
			report_fault($sformatf("no result for a batch of %0d samples", want.used));
		end

		$display("Covered %0d samples in %0d batches (%0d over-full) under %0d reference settings.",
			samples_taken, batches_seen, spilled_batches, ref_settings);
		$display("Checked %0d results, %0d field mismatches.", results_checked, fault_count);
		if (fault_count == 0)
			$display("accel_batch_tilt_angles_core verification clean");
		else
			$display("accel_batch_tilt_angles_core verification failed");
		$finish;
	end

endmodule

[accel_batch_tilt_angles_core.f]
hw/rtl/atbt_pkg.sv
hw/rtl/atbt_sample_if.sv
hw/rtl/atbt_result_if.sv
hw/rtl/atbt_isqrt.sv
hw/rtl/atbt_cordic.sv
hw/rtl/accel_batch_tilt_angles_core.sv
tb/sv/accel_batch_tilt_angles_core_test.sv
